>>> hw/rtl/assert_macros.svh
// assertion macros used by the cache top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/sacm_pkg.sv
// types and constants of the set-associative cache with mru-bit replacement
package sacm_pkg;

    localparam int MAX_SETS     = 1024;
    localparam int MAX_WAYS     = 8;
    localparam int SET_BITS     = $clog2(MAX_SETS);
    localparam int WAY_BITS     = 3;
    localparam int WAY_CNT_BITS = 4;
    localparam int SET_CNT_BITS = 11;
    localparam int WPB_BITS     = 7;
    localparam int WPB_MAX      = 64;
    localparam int ADDR_BITS    = 32;
    localparam int BYTE_BITS    = 2;
    localparam int TAG_BITS     = 30;
    localparam int DIV_STEPS    = TAG_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SET_COUNT       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WORDS_PER_BLOCK = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAY_COUNT       = 2'd2;

    localparam logic [SET_CNT_BITS-1:0] SET_COUNT_RST = 11'd16;
    localparam logic [WPB_BITS-1:0]     WPB_RST       = 7'd4;
    localparam logic [WAY_CNT_BITS-1:0] WAY_COUNT_RST = 4'd4;

    localparam logic CMD_ACCESS     = 1'b0;
    localparam logic CMD_INVALIDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BLOCK,
        ST_SET,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]               valid;
        logic [MAX_WAYS-1:0]               mru;
        logic [MAX_WAYS-1:0][TAG_BITS-1:0] tag;
    } row_t;

    typedef struct packed {
        logic                    start;
        logic [TAG_BITS-1:0]     dividend;
        logic [SET_CNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [TAG_BITS-1:0]     quotient;
        logic [SET_CNT_BITS-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                wr_en;
        logic [SET_BITS-1:0] addr;
        row_t                wdata;
    } ram_req_t;

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
        logic                filled;
    } lookup_t;

endpackage

>>> hw/rtl/sacm_div.sv
// restoring divider, one quotient bit per cycle, shared by block and set steps
module sacm_div
    import sacm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [SET_CNT_BITS-1:0] rem_reg, rem_next;
    logic [TAG_BITS-1:0]     quo_reg, quo_next;
    logic [SET_CNT_BITS-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [SET_CNT_BITS:0]   trial;
    logic [SET_CNT_BITS:0]   diff;
    logic                    ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[TAG_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[SET_CNT_BITS-1:0] : trial[SET_CNT_BITS-1:0];
            quo_next = {quo_reg[TAG_BITS-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hw/rtl/sacm_row_ram.sv
// one row per set: valid, mru and tag of every way, registered read
module sacm_row_ram
    import sacm_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output row_t     rdata
);

    row_t mem [MAX_SETS];
    row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sacm_update.sv
// way match, invalidation, victim choice and mru update for one set row
module sacm_update
    import sacm_pkg::*;
(
    input  row_t                    row,
    input  logic                    command,
    input  logic [TAG_BITS-1:0]     tag,
    input  logic [WAY_CNT_BITS-1:0] ways,
    output row_t                    new_row,
    output lookup_t                 res
);

    logic [MAX_WAYS-1:0] use_m;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] empty;
    logic [MAX_WAYS-1:0] clr;
    logic [MAX_WAYS-1:0] onehot;
    logic [MAX_WAYS-1:0] mru_set;
    logic [WAY_BITS-1:0] w_match;
    logic [WAY_BITS-1:0] w_empty;
    logic [WAY_BITS-1:0] w_clr;
    logic [WAY_BITS-1:0] way;
    logic                all_set;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            use_m[i] = WAY_CNT_BITS'(i) < ways;
            match[i] = use_m[i] && row.valid[i] && (row.tag[i] == tag);
            empty[i] = use_m[i] && !row.valid[i];
            clr[i]   = use_m[i] && !row.mru[i];
        end
        w_match = '0;
        w_empty = '0;
        w_clr   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                w_match = WAY_BITS'(i);
            end
            if (empty[i])
            begin
                w_empty = WAY_BITS'(i);
            end
            if (clr[i])
            begin
                w_clr = WAY_BITS'(i);
            end
        end

        new_row = row;
        res     = '0;
        way     = '0;
        onehot  = '0;
        mru_set = row.mru;
        all_set = 1'b0;
        if (command == CMD_INVALIDATE)
        begin
            res.hit       = |match;
            res.way       = w_match;
            new_row.valid = row.valid & ~match;
        end
        else
        begin
            if (|match)
            begin
                way     = w_match;
                res.hit = 1'b1;
            end
            else if (|empty)
            begin
                way        = w_empty;
                res.filled = 1'b1;
            end
            else if (|clr)
            begin
                way = w_clr;
            end
            res.way = way;
            onehot  = MAX_WAYS'(1) << way;
            // miss: install the tag in the chosen way
            if (!res.hit)
            begin
                new_row.valid = row.valid | onehot;
                for (int i = 0; i < MAX_WAYS; i++)
                begin
                    if (onehot[i])
                    begin
                        new_row.tag[i] = tag;
                    end
                end
            end
            // with more than one way in use: mark mru, fold back when every way in use is valid and marked
            if (ways != WAY_CNT_BITS'(1))
            begin
                mru_set     = row.mru | onehot;
                all_set     = &((new_row.valid & mru_set) | ~use_m);
                new_row.mru = all_set ? ((mru_set & ~use_m) | onehot) : mru_set;
            end
        end
    end

endmodule

>>> hw/rtl/set_assoc_cache_mru_bits_core.sv
// top level of the tag-only set-associative cache with mru-bit replacement
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  request  | start, busy            | command, phys_addr
//  result   | done (one-cycle pulse) | hit, way_used, filled_empty
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// a request goes from accept to the done pulse through two 30-step divisions
// on one shared restoring divider, one row read and one row update
// busy drops in the cycle that done is shown, and a new request may start then
// after reset a clearing pass writes all 1024 set rows, one per cycle; busy is
// high meanwhile, config writes are taken at all times
// the result receiver cannot stall: done lasts exactly one cycle
`include "assert_macros.svh"

module set_assoc_cache_mru_bits_core
    import sacm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    command,
    input  logic [ADDR_BITS-1:0]    phys_addr,
    output logic                    done,
    output logic                    hit,
    output logic [WAY_BITS-1:0]     way_used,
    output logic                    filled_empty,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SET_CNT_BITS-1:0] cfg_data
);

    state_t                  state_reg, state_next;
    logic [SET_BITS-1:0]     clr_reg, clr_next;
    logic                    cmd_reg, cmd_next;
    logic [SET_BITS-1:0]     idx_reg, idx_next;
    logic [TAG_BITS-1:0]     tag_reg, tag_next;
    logic                    done_reg, done_next;
    lookup_t                 out_reg, out_next;
    logic [SET_CNT_BITS-1:0] set_count_reg;
    logic [WPB_BITS-1:0]     wpb_reg;
    logic [WAY_CNT_BITS-1:0] way_count_reg;
    logic [SET_CNT_BITS-1:0] sets_eff;
    logic [WPB_BITS-1:0]     wpb_eff;
    logic [WAY_CNT_BITS-1:0] ways_eff;
    div_req_t                div_req;
    div_rsp_t                div_rsp;
    ram_req_t                ram_req;
    row_t                    rd_row;
    row_t                    upd_row;
    lookup_t                 upd_res;

    // register saturation, zero acts as one
    always_comb
    begin
        if (set_count_reg == '0)
        begin
            sets_eff = SET_CNT_BITS'(1);
        end
        else if (set_count_reg > SET_CNT_BITS'(MAX_SETS))
        begin
            sets_eff = SET_CNT_BITS'(MAX_SETS);
        end
        else
        begin
            sets_eff = set_count_reg;
        end
        if (wpb_reg == '0)
        begin
            wpb_eff = WPB_BITS'(1);
        end
        else if (wpb_reg > WPB_BITS'(WPB_MAX))
        begin
            wpb_eff = WPB_BITS'(WPB_MAX);
        end
        else
        begin
            wpb_eff = wpb_reg;
        end
        if (way_count_reg == '0)
        begin
            ways_eff = WAY_CNT_BITS'(1);
        end
        else if (way_count_reg > WAY_CNT_BITS'(MAX_WAYS))
        begin
            ways_eff = WAY_CNT_BITS'(MAX_WAYS);
        end
        else
        begin
            ways_eff = way_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg <= SET_COUNT_RST;
            wpb_reg       <= WPB_RST;
            way_count_reg <= WAY_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SET_COUNT:       set_count_reg <= cfg_data;
                CFG_WORDS_PER_BLOCK: wpb_reg       <= cfg_data[WPB_BITS-1:0];
                CFG_WAY_COUNT:       way_count_reg <= cfg_data[WAY_CNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    sacm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sacm_row_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rd_row)
    );

    sacm_update u_update (
        .row     (rd_row),
        .command (cmd_reg),
        .tag     (tag_reg),
        .ways    (ways_eff),
        .new_row (upd_row),
        .res     (upd_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        tag_next      = tag_reg;
        done_next     = 1'b0;
        out_next      = out_reg;
        div_req       = '0;
        ram_req.wr_en = 1'b0;
        ram_req.addr  = idx_reg;
        ram_req.wdata = upd_row;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + SET_BITS'(1);
                if (clr_reg == SET_BITS'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next         = command;
                    div_req.start    = 1'b1;
                    div_req.dividend = phys_addr[ADDR_BITS-1:BYTE_BITS];
                    div_req.divisor  = SET_CNT_BITS'(wpb_eff);
                    state_next       = ST_BLOCK;
                end
            end
            ST_BLOCK:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = sets_eff;
                    state_next       = ST_SET;
                end
            end
            ST_SET:
            begin
                if (div_rsp.done)
                begin
                    idx_next   = div_rsp.remainder[SET_BITS-1:0];
                    tag_next   = div_rsp.quotient;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ram_req.wr_en = 1'b1;
                out_next      = upd_res;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        tag_reg <= tag_next;
        out_reg <= out_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign hit          = out_reg.hit;
    assign way_used     = out_reg.way;
    assign filled_empty = out_reg.filled;

    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_fill_miss, clk, rst_n, done && filled_empty, !hit)
    `ASSERT_IMPLY(a_way_range, clk, rst_n, done, WAY_CNT_BITS'(way_used) < ways_eff)

endmodule

>>> tb/tb.sv
// testbench for the set-associative cache with mru-bit replacement: predicted lookups vs results
module tb;
    import sacm_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 70;
    localparam int PHASE_COUNT    = 10;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    command = CMD_ACCESS;
    logic [ADDR_BITS-1:0]    phys_addr = '0;
    logic                    done;
    logic                    hit;
    logic [WAY_BITS-1:0]     way_used;
    logic                    filled_empty;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_SET_COUNT;
    logic [SET_CNT_BITS-1:0] cfg_data = '0;

    // predictor copy of the registers and the tag store
    logic [SET_CNT_BITS-1:0] cfg_sets = SET_COUNT_RST;
    logic [WPB_BITS-1:0]     cfg_wpb  = WPB_RST;
    logic [WAY_CNT_BITS-1:0] cfg_ways = WAY_COUNT_RST;
    logic                    line_v [MAX_SETS][MAX_WAYS];
    logic                    line_m [MAX_SETS][MAX_WAYS];
    logic [TAG_BITS-1:0]     line_t [MAX_SETS][MAX_WAYS];

    lookup_t pending_lookups [$];
    int      fail_count = 0;
    int      quiet_cycles = 0;
    bit      gaps_on = 1'b1;

    set_assoc_cache_mru_bits_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .phys_addr    (phys_addr),
        .done         (done),
        .hit          (hit),
        .way_used     (way_used),
        .filled_empty (filled_empty),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned clamp_val(int unsigned v, int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void touch_way(int unsigned s, int unsigned ways, int unsigned w);
        bit all_set;
        if (ways == 1)
        begin
            return;
        end
        line_m[s][w] = 1'b1;
        all_set = 1'b1;
        for (int i = 0; i < ways; i++)
        begin
            if (!line_v[s][i] || !line_m[s][i])
            begin
                all_set = 1'b0;
            end
        end
        if (all_set)
        begin
            for (int i = 0; i < ways; i++)
            begin
                line_m[s][i] = 1'b0;
            end
            line_m[s][w] = 1'b1;
        end
    endfunction

    function automatic lookup_t cache_lookup(logic cmd, logic [ADDR_BITS-1:0] addr);
        int unsigned         sets;
        int unsigned         wpb;
        int unsigned         ways;
        int unsigned         blk;
        int unsigned         s;
        logic [TAG_BITS-1:0] tg;
        lookup_t             r;
        bit                  found;
        sets  = clamp_val(32'(cfg_sets), MAX_SETS);
        wpb   = clamp_val(32'(cfg_wpb), WPB_MAX);
        ways  = clamp_val(32'(cfg_ways), MAX_WAYS);
        blk   = (addr >> BYTE_BITS) / wpb;
        s     = blk % sets;
        tg    = TAG_BITS'(blk / sets);
        r     = '0;
        found = 1'b0;
        if (cmd == CMD_INVALIDATE)
        begin
            for (int i = 0; i < ways; i++)
            begin
                if (line_v[s][i] && line_t[s][i] == tg)
                begin
                    if (!found)
                    begin
                        r.way = WAY_BITS'(i);
                        found = 1'b1;
                    end
                    line_v[s][i] = 1'b0;
                end
            end
            r.hit = found;
        end
        else
        begin
            for (int i = 0; i < ways && !found; i++)
            begin
                if (line_v[s][i] && line_t[s][i] == tg)
                begin
                    r.way = WAY_BITS'(i);
                    found = 1'b1;
                end
            end
            if (found)
            begin
                r.hit = 1'b1;
                touch_way(s, ways, 32'(r.way));
            end
            else
            begin
                for (int i = 0; i < ways && !found; i++)
                begin
                    if (!line_v[s][i])
                    begin
                        r.way    = WAY_BITS'(i);
                        r.filled = 1'b1;
                        found    = 1'b1;
                    end
                end
                for (int i = 0; i < ways && !found; i++)
                begin
                    if (!line_m[s][i])
                    begin
                        r.way = WAY_BITS'(i);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    r.way = '0;
                end
                line_v[s][r.way] = 1'b1;
                line_t[s][r.way] = tg;
                touch_way(s, ways, 32'(r.way));
            end
        end
        return r;
    endfunction

    // byte address of a given tag, set and offset under the current sizes
    function automatic logic [ADDR_BITS-1:0] addr_of(int unsigned tg, int unsigned s,
                                                     int unsigned off);
        longint unsigned blk;
        longint unsigned sets;
        longint unsigned wpb;
        sets = longint'(clamp_val(32'(cfg_sets), MAX_SETS));
        wpb  = longint'(clamp_val(32'(cfg_wpb), WPB_MAX));
        blk  = longint'(tg) * sets + longint'(s);
        return ADDR_BITS'(((blk * wpb) << BYTE_BITS) + longint'(off));
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 4);
        end
        if (r < 95)
        begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(30, 100);
    endfunction

    task automatic send_request(logic cmd, logic [ADDR_BITS-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        phys_addr <= addr;
        do @(posedge clk); while (busy);
        pending_lookups.push_back(cache_lookup(cmd, addr));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SET_CNT_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SET_COUNT:       cfg_sets = data;
            CFG_WORDS_PER_BLOCK: cfg_wpb  = data[WPB_BITS-1:0];
            CFG_WAY_COUNT:       cfg_ways = data[WAY_CNT_BITS-1:0];
            default:             ;
        endcase
    endtask

    task automatic set_config(logic [SET_CNT_BITS-1:0] sc, logic [SET_CNT_BITS-1:0] wpb,
                              logic [SET_CNT_BITS-1:0] wc);
        wait_idle();
        write_reg(CFG_SET_COUNT, sc);
        write_reg(CFG_WORDS_PER_BLOCK, wpb);
        write_reg(CFG_WAY_COUNT, wc);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_access();
        send_request(CMD_ACCESS, 32'h0000_0000);
        send_request(CMD_ACCESS, 32'h0000_0003);
        send_request(CMD_ACCESS, 32'hFFFF_FFFF);
        send_request(CMD_ACCESS, 32'hFFFF_FFF0);
    endtask

    // fill set 0, wrap the mru bits, then evict
    task automatic test_replacement();
        send_request(CMD_ACCESS, addr_of(1, 0, 0));
        send_request(CMD_ACCESS, addr_of(2, 0, 4));
        send_request(CMD_ACCESS, addr_of(3, 0, 8));
        send_request(CMD_ACCESS, addr_of(0, 0, 0));
        send_request(CMD_ACCESS, addr_of(1, 0, 0));
        send_request(CMD_ACCESS, addr_of(5, 0, 12));
    endtask

    task automatic test_invalidate();
        send_request(CMD_INVALIDATE, addr_of(5, 0, 0));
        send_request(CMD_INVALIDATE, addr_of(5, 0, 0));
        send_request(CMD_ACCESS, addr_of(7, 0, 0));
        send_request(CMD_INVALIDATE, 32'hFFFF_FFFF);
    endtask

    // shrinking the way count leaves no clear mru bit among the ways in use
    task automatic test_way_shrink();
        for (int t = 0; t < 4; t++)
        begin
            send_request(CMD_ACCESS, addr_of(t, 1, 0));
        end
        send_request(CMD_ACCESS, addr_of(0, 1, 0));
        send_request(CMD_ACCESS, addr_of(1, 1, 0));
        set_config(SET_COUNT_RST, SET_CNT_BITS'(WPB_RST), 11'd2);
        send_request(CMD_ACCESS, addr_of(7, 1, 0));
        set_config(SET_COUNT_RST, SET_CNT_BITS'(WPB_RST), 11'd1);
        send_request(CMD_ACCESS, addr_of(8, 1, 0));
    endtask

    task automatic test_register_limits();
        wait_idle();
        write_reg(CFG_SET_COUNT, '0);
        write_reg(CFG_WORDS_PER_BLOCK, '0);
        write_reg(CFG_WAY_COUNT, '0);
        write_reg(CFG_UNUSED, 11'h7FF);
        cfg_valid <= 1'b0;
        send_request(CMD_ACCESS, 32'h0000_0010);
        send_request(CMD_ACCESS, 32'h8000_0004);
        set_config(11'h7FF, 11'h7FF, 11'h7FF);
        send_request(CMD_ACCESS, 32'hFFFF_FFFC);
    endtask

    task automatic test_random_traffic();
        logic [SET_CNT_BITS-1:0] sc;
        logic [SET_CNT_BITS-1:0] wpb;
        logic [SET_CNT_BITS-1:0] wc;
        int unsigned             sets;
        int unsigned             bsize;
        int unsigned             ways;
        int unsigned             s;
        int unsigned             tg;
        int                      r;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin sc = 11'd16;   wpb = 11'd4;   wc = 11'd4;   end
                1: begin sc = 11'd1;    wpb = 11'd1;   wc = 11'd1;   end
                2: begin sc = 11'd1024; wpb = 11'd64;  wc = 11'd8;   end
                3: begin sc = 11'd2;    wpb = 11'd1;   wc = 11'd8;   end
                4: begin sc = 11'd0;    wpb = 11'd0;   wc = 11'd0;   end
                5: begin sc = 11'h7FF;  wpb = 11'd127; wc = 11'd15;  end
                6: begin sc = 11'd7;    wpb = 11'd3;   wc = 11'd5;   end
                7: begin sc = 11'd1024; wpb = 11'h7C1; wc = 11'h7F2; end
                default:
                begin
                    sc  = SET_CNT_BITS'($urandom_range(1, MAX_SETS));
                    wpb = SET_CNT_BITS'($urandom_range(1, WPB_MAX));
                    wc  = SET_CNT_BITS'($urandom_range(2, MAX_WAYS));
                end
            endcase
            set_config(sc, wpb, wc);
            gaps_on = ($urandom_range(0, 3) != 0);
            sets  = clamp_val(32'(cfg_sets), MAX_SETS);
            bsize = clamp_val(32'(cfg_wpb), WPB_MAX) << BYTE_BITS;
            ways  = clamp_val(32'(cfg_ways), MAX_WAYS);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    send_request(1'($urandom_range(0, 1)), $urandom());
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        s = $urandom_range(0, sets - 1);
                    end
                    else
                    begin
                        s = $urandom_range(0, (sets > 4) ? 3 : sets - 1);
                    end
                    if ($urandom_range(0, 19) == 0)
                    begin
                        tg = $urandom() >> 2;
                    end
                    else
                    begin
                        tg = $urandom_range(0, ways + 2);
                    end
                    send_request((r < 28) ? CMD_INVALIDATE : CMD_ACCESS,
                                 addr_of(tg, s, $urandom_range(0, bsize - 1)));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("unexpected result: hit %0b way %0d filled %0b",
                             hit, way_used, filled_empty);
                end
            end
            else
            begin
                e = pending_lookups.pop_front();
                if (hit !== e.hit || way_used !== e.way || filled_empty !== e.filled)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $write("mismatch: expected hit %0b way %0d filled %0b, ",
                               e.hit, e.way, e.filled);
                        $display("got hit %0b way %0d filled %0b",
                                 hit, way_used, filled_empty);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < MAX_SETS; s++)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                line_v[s][w] = 1'b0;
                line_m[s][w] = 1'b0;
                line_t[s][w] = '0;
            end
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_access();
        test_replacement();
        test_invalidate();
        test_way_shrink();
        test_register_limits();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_lookups.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
